/* design/assert_macros.svh */
// Assertion macros shared by the slot reference counter RTL.
// Each macro takes a label, the clock and the reset so that the callers stay short.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* design/icsrc_pkg.sv */
// Package for the indirect call slot reference counter.
// Holds the opcodes, the byte constants, the sizes and the queue entry type.
`default_nettype none

package icsrc_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(MAX_SLOTS + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_BEGIN = 2'd2;
  localparam logic [1:0] OP_SCAN = 2'd3;

  localparam logic [7:0] PREFIX_BYTE = 8'hFF;
  localparam logic [7:0] CALL_MODRM = 8'h15;
  localparam logic [7:0] JMP_MODRM = 8'h25;
  localparam logic [31:0] WINDOW_LEN = 32'd6;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] op;
    logic cand;
    logic [31:0] word;
  } icsrc_entry_t;

endpackage

`default_nettype wire

/* design/icsrc_if.sv */
// Request and result channel interfaces for the slot reference counter.
// Each carries valid, ready and the payload fields; no package is needed.
`default_nettype none

interface icsrc_in_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [31:0] slot_address;
  logic [7:0] code_byte;

  modport source (output valid, opcode, slot_address, code_byte, input ready);
  modport sink (input valid, opcode, slot_address, code_byte, output ready);
endinterface

interface icsrc_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic [31:0] reference_total;
  logic status;

  modport source (output valid, matched, reference_total, status, input ready);
  modport sink (input valid, matched, reference_total, status, output ready);
endinterface

`default_nettype wire

/* design/indirect_call_slot_ref_counter_top.sv */
// Top level of the indirect call slot reference counter.
// Depends on icsrc_pkg, icsrc_if, icsrc_front, icsrc_queue and icsrc_back.
//
//   channel   direction  payload
//   in_ch     in         opcode, slot_address, code_byte
//   out_ch    out        matched, reference_total, status
//   cfg       in         cfg_we, cfg_wdata (range_base_address)
//
// The front end takes one request a cycle while the queue has room.
// With an idle back end, a request that is not a candidate window passes through the
// queue and then the output register before its result shows.
// From its pop to its result, a candidate window holds the back end while it searches
// the loaded slots, one slot memory read a cycle.
// Reset is synchronous and needs no memory clearing pass.
// A stalled result holds the back end; the front end keeps filling the four-entry queue.
`default_nettype none

module indirect_call_slot_ref_counter_top import icsrc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  icsrc_in_if.sink         in_ch,
  icsrc_out_if.source      out_ch
);

  logic         push;
  icsrc_entry_t push_entry;
  logic         full;
  logic         pop;
  icsrc_entry_t head;
  logic         empty;

  icsrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (full),
    .push      (push),
    .push_entry(push_entry)
  );

  icsrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  icsrc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

`default_nettype wire

/* design/icsrc_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// Stands alone; width and depth come from its parameters.
`default_nettype none

module icsrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/icsrc_front.sv */
// Front end: accepts requests, keeps the byte window and the range offset,
// and classifies each request into a queue entry. Uses icsrc_pkg and icsrc_if.
`default_nettype none

module icsrc_front import icsrc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  icsrc_in_if.sink         in_ch,
  input  wire logic        q_full,
  output logic             push,
  output icsrc_entry_t     push_entry
);

  logic [31:0] base;
  logic [47:0] window;
  logic [31:0] bytes_seen;
  logic [47:0] window_next;
  logic [31:0] bytes_next;
  logic [31:0] disp;
  logic [31:0] target;
  logic        is_ref;

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && !q_full;

  always_comb begin
    window_next = {window[39:0], in_ch.code_byte};
    bytes_next = bytes_seen + 32'd1;
    disp = {window_next[7:0], window_next[15:8], window_next[23:16], window_next[31:24]};
    target = base + bytes_next + disp;
    is_ref = (bytes_next >= WINDOW_LEN) && (window_next[47:40] == PREFIX_BYTE) &&
             ((window_next[39:32] == CALL_MODRM) || (window_next[39:32] == JMP_MODRM));
    push_entry.op = in_ch.opcode;
    push_entry.cand = (in_ch.opcode == OP_SCAN) && is_ref;
    push_entry.word = (in_ch.opcode == OP_LOAD) ? in_ch.slot_address : target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      window <= '0;
      bytes_seen <= '0;
    end else begin
      if (cfg_we) begin
        base <= cfg_wdata;
      end
      if (push) begin
        case (in_ch.opcode)
          OP_BEGIN: begin
            window <= '0;
            bytes_seen <= '0;
          end
          OP_SCAN: begin
            window <= window_next;
            bytes_seen <= bytes_next;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* design/icsrc_queue.sv */
// Short request queue between the front end and the back end.
// Uses icsrc_pkg for the entry type and depth.
`default_nettype none

`include "assert_macros.svh"

module icsrc_queue import icsrc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire icsrc_entry_t push_entry,
  output logic              full,
  input  wire logic         pop,
  output icsrc_entry_t      head,
  output logic              empty
);

  icsrc_entry_t    entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full = (count == Q_CW'(Q_DEPTH));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, full, !push)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, empty, !pop)
  `ASSERT_ALWAYS(a_queue_count_bound, clk, rst, count <= Q_CW'(Q_DEPTH))

endmodule

`default_nettype wire

/* design/icsrc_back.sv */
// Back end: owns the slot memory, the slot count and the running total.
// Searches the slot memory one entry a cycle. Uses icsrc_pkg, icsrc_if, icsrc_ram.
`default_nettype none

`include "assert_macros.svh"

module icsrc_back import icsrc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         empty,
  input  wire icsrc_entry_t head,
  output logic              pop,
  icsrc_out_if.source       out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state;
  logic [SLOT_CW-1:0] n;
  logic [SLOT_CW-1:0] idx;
  logic [31:0]        target;
  logic [31:0]        total;
  logic               cmp_valid;
  logic               hit;
  logic               o_valid;
  logic               o_matched;
  logic [31:0]        o_total;
  logic               o_status;
  logic               o_load;
  logic               out_free;
  logic               issue;
  logic               found;
  logic               room;
  logic               mem_we;
  logic [31:0]        rdata;
  logic [31:0]        total_inc;

  assign out_free = !o_valid || out_ch.ready;
  assign issue = (state == ST_SEARCH) && (idx != n) && !found;
  assign found = cmp_valid && (rdata == target);
  assign room = (n < SLOT_CW'(MAX_SLOTS));
  assign pop = (state == ST_IDLE) && !empty && (head.cand || out_free);
  assign mem_we = pop && !head.cand && (head.op == OP_LOAD) && room;
  assign total_inc = (total != TOTAL_MAX) ? total + 32'd1 : total;
  assign o_load = (pop && !head.cand) || ((state == ST_DONE) && out_free);

  assign out_ch.valid = o_valid;
  assign out_ch.matched = o_matched;
  assign out_ch.reference_total = o_total;
  assign out_ch.status = o_status;

  icsrc_ram #(
    .WIDTH(32),
    .DEPTH(MAX_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(n[SLOT_AW-1:0]),
    .wdata(head.word),
    .re   (issue),
    .raddr(idx[SLOT_AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n <= '0;
      idx <= '0;
      total <= '0;
      cmp_valid <= 1'b0;
      hit <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (issue) begin
        idx <= idx + SLOT_CW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (pop && head.cand) begin
            target <= head.word;
            idx <= '0;
            state <= ST_SEARCH;
          end else if (pop) begin
            o_matched <= 1'b0;
            o_status <= 1'b0;
            o_total <= total;
            case (head.op)
              OP_CLEAR: begin
                n <= '0;
                total <= '0;
                o_total <= '0;
              end
              OP_LOAD: begin
                if (room) begin
                  n <= n + SLOT_CW'(1);
                end else begin
                  o_status <= 1'b1;
                end
              end
              OP_BEGIN: begin
                total <= '0;
                o_total <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SEARCH: begin
          if (found) begin
            hit <= 1'b1;
            state <= ST_DONE;
          end else if ((idx == n) && !cmp_valid) begin
            hit <= 1'b0;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            o_matched <= hit;
            o_status <= 1'b0;
            o_total <= hit ? total_inc : total;
            if (hit) begin
              total <= total_inc;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, n <= SLOT_CW'(MAX_SLOTS))
  `ASSERT_IMPLIES(a_idx_bound, clk, rst, state == ST_SEARCH, idx <= n)
  `ASSERT_IMPLIES(a_cmp_in_search, clk, rst, cmp_valid, state == ST_SEARCH)

endmodule

`default_nettype wire
